[design/toc_pkg.sv]
// Package for the timed output command controller.
// Holds the state struct, the command codes and the timing constants.
// No dependencies.
package toc_pkg;

    // command codes
    localparam logic [7:0] CMD_CLEAR  = 8'h00;
    localparam logic [7:0] CMD_SET    = 8'h01;
    localparam logic [7:0] CMD_TOGGLE = 8'h02;
    localparam logic [7:0] CMD_NONE   = 8'hFF;

    // command groups taken from the upper nibble
    localparam logic [3:0] GRP_CANCEL    = 4'h0;
    localparam logic [3:0] GRP_BLINK_SEC = 4'h1;
    localparam logic [3:0] GRP_BLINK_TEN = 4'h2;

    // delayed close / open ranges taken from the upper two bits
    localparam logic [1:0] RNG_CLOSE = 2'b01;
    localparam logic [1:0] RNG_OPEN  = 2'b10;

    // input function codes
    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // millisecond scale factors
    localparam logic [15:0] MS_PER_SEC   = 16'd1000;
    localparam logic [15:0] MS_PER_TENTH = 16'd100;

    // controller state
    typedef struct packed {
        logic        level;
        logic [7:0]  pending;
        logic [15:0] ms_left;
        logic        armed;
    } t_state;

endpackage

[design/toc_exec.sv]
// Command execution logic for the timed output controller.
// Maps one command byte and the current state to the next state.
// Depends on toc_pkg.
module toc_exec (
    input  logic [7:0]      i_cmd,
    input  toc_pkg::t_state i_state,
    output toc_pkg::t_state o_state
);

    logic [5:0]  w_secs;
    logic [15:0] w_sec_ms;
    logic [15:0] w_tenth_ms;
    logic [15:0] w_delay;
    logic        w_arm;

    // delay in milliseconds for the timed groups
    assign w_secs     = (i_cmd[7:4] == toc_pkg::GRP_BLINK_SEC) ? {2'b00, i_cmd[3:0]}
                                                               : i_cmd[5:0];
    assign w_sec_ms   = 16'(w_secs) * toc_pkg::MS_PER_SEC;
    assign w_tenth_ms = 16'(i_cmd[3:0]) * toc_pkg::MS_PER_TENTH;
    assign w_delay    = (i_cmd[7:4] == toc_pkg::GRP_BLINK_TEN) ? w_tenth_ms : w_sec_ms;

    // decode and apply the command
    always_comb begin
        o_state = i_state;
        w_arm   = 1'b0;
        if (i_cmd != toc_pkg::CMD_NONE) begin
            if (i_cmd[7:4] == toc_pkg::GRP_CANCEL) begin
                if (i_cmd == toc_pkg::CMD_CLEAR) begin
                    o_state.level = 1'b0;
                end else if (i_cmd == toc_pkg::CMD_SET) begin
                    o_state.level = 1'b1;
                end else if (i_cmd == toc_pkg::CMD_TOGGLE) begin
                    o_state.level = ~i_state.level;
                end
                o_state.pending = toc_pkg::CMD_NONE;
                o_state.armed   = 1'b0;
                o_state.ms_left = '0;
            end else if (i_cmd[7:4] == toc_pkg::GRP_BLINK_SEC ||
                         i_cmd[7:4] == toc_pkg::GRP_BLINK_TEN) begin
                o_state.level   = ~i_state.level;
                o_state.pending = i_cmd;
                w_arm           = 1'b1;
            end else if (i_cmd[7:6] == toc_pkg::RNG_CLOSE) begin
                o_state.pending = toc_pkg::CMD_CLEAR;
                w_arm           = 1'b1;
            end else if (i_cmd[7:6] == toc_pkg::RNG_OPEN) begin
                o_state.pending = toc_pkg::CMD_SET;
                w_arm           = 1'b1;
            end
            // a zero delay leaves the timer as it was
            if (w_arm && w_delay != 16'd0) begin
                o_state.ms_left = w_delay;
                o_state.armed   = 1'b1;
            end
        end
    end

endmodule

[design/toc_state.sv]
// State register and tick handling of the timed output controller.
// Counts the timer down and runs the pending command at expiry.
// Depends on toc_pkg and toc_exec.
module toc_state (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_func,
    input  logic [7:0]      i_cmd,
    output toc_pkg::t_state o_next
);

    toc_pkg::t_state r_state;
    toc_pkg::t_state n_state;
    toc_pkg::t_state w_base;
    toc_pkg::t_state w_exec;
    logic [7:0]      w_cmd;
    logic            w_running;

    assign w_running = r_state.armed && (r_state.ms_left > 16'd1);

    // a tick at expiry runs the pending command on a disarmed state
    always_comb begin
        w_base = r_state;
        w_cmd  = i_cmd;
        if (i_func == toc_pkg::FUNC_TICK) begin
            w_base.ms_left = '0;
            w_base.armed   = 1'b0;
            w_cmd          = r_state.pending;
        end
    end

    toc_exec u_exec (
        .i_cmd   (w_cmd),
        .i_state (w_base),
        .o_state (w_exec)
    );

    // next state selection
    always_comb begin
        n_state = r_state;
        if (i_func == toc_pkg::FUNC_CMD) begin
            n_state = w_exec;
        end else if (w_running) begin
            n_state.ms_left = r_state.ms_left - 16'd1;
        end else if (r_state.armed) begin
            n_state = w_exec;
        end
    end

    assign o_next = n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.level   <= 1'b0;
            r_state.pending <= toc_pkg::CMD_NONE;
            r_state.ms_left <= '0;
            r_state.armed   <= 1'b0;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    // an idle timer holds zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.armed |-> r_state.ms_left == 16'd0)
        else $error("timer idle with nonzero count");

    // an armed timer never sits at zero
    a_armed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.armed |-> r_state.ms_left != 16'd0)
        else $error("timer armed with zero count");

    // an armed timer always has something to run
    a_armed_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.armed |-> r_state.pending != toc_pkg::CMD_NONE)
        else $error("timer armed with no pending command");

    // a tick on a running timer counts down by one
    a_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_func == toc_pkg::FUNC_TICK && w_running
        |=> r_state.armed && r_state.ms_left == $past(r_state.ms_left) - 16'd1)
        else $error("tick did not count down");

endmodule

[design/timed_output_command_controller_top.sv]
// Top level of the timed output command controller.
// Input register, state update and result register; depends on toc_pkg and toc_state.
// Depends on toc_pkg and toc_state.

// Takes one item per clock cycle while the output side is not stalled: a
// command byte (i_func = 0) or a one millisecond tick (i_func = 1), and
// returns one result per item with the output level and whether a delayed
// action is armed. An item passes an input register, one pass of decode and
// timer logic that also updates the controller state, and a result register.
// A stall on the output side holds the result register and then the input
// register; the state advances only when an item moves into the result
// register.
module timed_output_command_controller_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_func,
    input  logic [7:0] i_cmd,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_level,
    output logic       o_busy_res
);

    logic            r_in_valid;
    logic            r_func;
    logic [7:0]      r_cmd;
    logic            r_out_valid;
    logic            r_level;
    logic            r_busy;
    logic            w_adv;
    toc_pkg::t_state w_next;

    // move the held item into the result register
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func <= i_func;
            r_cmd  <= i_cmd;
        end
    end

    toc_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_func  (r_func),
        .i_cmd   (r_cmd),
        .o_next  (w_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_level <= w_next.level;
            r_busy  <= w_next.armed;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_level    = r_level;
    assign o_busy_res = r_busy;

    // a held item stays put while the result register is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_cmd) && $stable(r_func))
        else $error("held item lost while stalled");

    // a result that is not taken is kept
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_level) && $stable(r_busy))
        else $error("result changed while stalled");

    // an item always advances when the result register is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_out_valid |-> w_adv)
        else $error("item not advanced into free result register");

endmodule
